// ===== sv/sfr_pkg.sv =====
// sfr_pkg: shared types, constants and register indexes for the sensor frame reader
// used by sfr_front, sfr_back, sfr_res_q and the top level; no dependencies
`timescale 1ns / 1ps

package sfr_pkg;

  // counter width and its saturation value
  localparam int unsigned CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // frame layout
  localparam int unsigned PHASE_BITS = 7;
  localparam logic [PHASE_BITS-1:0] PHASE_LAST = 7'd82;
  localparam logic [PHASE_BITS-1:0] FIRST_BIT_PHASE = 7'd4;
  localparam int unsigned FRAME_BITS = 40;

  // configuration port
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRE_WAIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_LOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_THRESH = 2'd3;

  // register reset values
  localparam logic [CNT_BITS-1:0] PRE_WAIT_RST = 16'd500;
  localparam logic [CNT_BITS-1:0] START_LOW_RST = 16'd20;
  localparam logic [CNT_BITS-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [CNT_BITS-1:0] ONE_THRESH_RST = 16'd20;

  // read status codes
  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_TIMEOUT = 2'd1;
  localparam logic [1:0] STS_CHECKSUM = 2'd2;
  localparam logic [1:0] STS_UNUSED = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PRE  = 4'b0010,
    ST_LOW  = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  // one input word
  typedef struct packed {
    logic line_level;
    logic start_read;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_tenths;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_tenths;
    logic [7:0] received_sum;
  } res_t;

  // handshake between the stages
  typedef struct packed {
    logic valid;
    logic take;
  } hs_t;

endpackage

// ===== sv/sfr_front.sv =====
// sfr_front: two-word input queue that takes line samples from the push side
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::in_word_t din,
  output logic             full,
  input  logic             take,
  output logic             valid,
  output sfr_pkg::in_word_t dout
);

  logic [1:0]        cnt_r, cnt_nxt;
  sfr_pkg::in_word_t slot0_r, slot1_r;
  logic              push_fire;

  assign push_fire = push && !full;
  assign full = cnt_r[1];
  assign valid = (cnt_r != 2'd0);
  assign dout = slot0_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push_fire && !take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (take && !push_fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // storage slots, oldest word in slot0
  always_ff @(posedge clk) begin
    if (take) begin
      if (cnt_r == 2'd2) begin
        slot0_r <= slot1_r;
        if (push_fire) begin
          slot1_r <= din;
        end
      end else if (push_fire) begin
        slot0_r <= din;
      end
    end else if (push_fire) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= din;
      end else begin
        slot1_r <= din;
      end
    end
  end

endmodule

// ===== sv/sfr_back.sv =====
// sfr_back: configuration registers and the read sequencer, one sample per taken word
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfr_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [sfr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                in_valid,
  input  sfr_pkg::in_word_t                   in_word,
  input  logic                                res_ready,
  output sfr_pkg::hs_t                        hs,
  output sfr_pkg::res_t                       res_word
);

  logic [sfr_pkg::CNT_BITS-1:0]   pre_wait_r, start_low_r, timeout_r, one_thresh_r;
  sfr_pkg::state_t                state_r, state_nxt;
  logic [sfr_pkg::CNT_BITS-1:0]   wait_cnt_r, wait_cnt_nxt;
  logic [sfr_pkg::PHASE_BITS-1:0] phase_idx_r, phase_idx_nxt;
  logic [sfr_pkg::CNT_BITS-1:0]   phase_ticks_r, phase_ticks_nxt;
  logic [sfr_pkg::FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [1:0]                     last_sts_r, last_sts_nxt;
  logic                           drive, done;
  logic                           take;
  logic [7:0]                     sum;

  assign take = in_valid && res_ready;
  assign hs.valid = in_valid;
  assign hs.take = take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_wait_r   <= sfr_pkg::PRE_WAIT_RST;
      start_low_r  <= sfr_pkg::START_LOW_RST;
      timeout_r    <= sfr_pkg::TIMEOUT_RST;
      one_thresh_r <= sfr_pkg::ONE_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sfr_pkg::CFG_PRE_WAIT:   pre_wait_r <= cfg_wdata;
        sfr_pkg::CFG_START_LOW:  start_low_r <= cfg_wdata;
        sfr_pkg::CFG_TIMEOUT:    timeout_r <= cfg_wdata;
        sfr_pkg::CFG_ONE_THRESH: one_thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one sample step: read phases first, then pre-wait and start pulse
  always_comb begin
    state_nxt       = state_r;
    wait_cnt_nxt    = wait_cnt_r;
    phase_idx_nxt   = phase_idx_r;
    phase_ticks_nxt = phase_ticks_r;
    shift_nxt       = shift_r;
    last_sts_nxt    = last_sts_r;
    drive           = 1'b0;
    done            = 1'b0;
    sum             = 8'd0;

    case (state_r)
      sfr_pkg::ST_IDLE: begin
        if (in_word.start_read) begin
          state_nxt    = sfr_pkg::ST_PRE;
          wait_cnt_nxt = '0;
          shift_nxt    = '0;
        end
      end
      sfr_pkg::ST_READ: begin
        // even phases are high, odd phases low
        if (in_word.line_level == !phase_idx_r[0]) begin
          if (phase_ticks_r < sfr_pkg::CNT_MAX) begin
            phase_ticks_nxt = phase_ticks_r + 1'b1;
          end
          if (phase_ticks_nxt >= timeout_r) begin
            last_sts_nxt = sfr_pkg::STS_TIMEOUT;
            state_nxt    = sfr_pkg::ST_IDLE;
            done         = 1'b1;
          end
        end else begin
          // end of a data high phase gives one bit
          if (!phase_idx_r[0] && phase_idx_r >= sfr_pkg::FIRST_BIT_PHASE) begin
            shift_nxt = {shift_r[sfr_pkg::FRAME_BITS-2:0], (phase_ticks_r > one_thresh_r)};
          end
          if (phase_idx_r >= sfr_pkg::PHASE_LAST) begin
            sum = shift_nxt[39:32] + shift_nxt[31:24] + shift_nxt[23:16] + shift_nxt[15:8];
            last_sts_nxt = (sum == shift_nxt[7:0]) ? sfr_pkg::STS_OK : sfr_pkg::STS_CHECKSUM;
            state_nxt    = sfr_pkg::ST_IDLE;
            done         = 1'b1;
          end else begin
            phase_idx_nxt   = phase_idx_r + 1'b1;
            phase_ticks_nxt = {{(sfr_pkg::CNT_BITS-1){1'b0}}, 1'b1};
            if (phase_ticks_nxt >= timeout_r) begin
              last_sts_nxt = sfr_pkg::STS_TIMEOUT;
              state_nxt    = sfr_pkg::ST_IDLE;
              done         = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // pre-wait, entered on the start tick itself
    if (state_nxt == sfr_pkg::ST_PRE) begin
      if (wait_cnt_nxt < pre_wait_r) begin
        wait_cnt_nxt = wait_cnt_nxt + 1'b1;
      end else begin
        state_nxt    = sfr_pkg::ST_LOW;
        wait_cnt_nxt = '0;
      end
    end

    // start pulse, then one released tick before sampling
    if (state_nxt == sfr_pkg::ST_LOW) begin
      if (wait_cnt_nxt < start_low_r) begin
        wait_cnt_nxt = wait_cnt_nxt + 1'b1;
        drive        = 1'b1;
      end else begin
        state_nxt       = sfr_pkg::ST_READ;
        wait_cnt_nxt    = '0;
        phase_idx_nxt   = '0;
        phase_ticks_nxt = '0;
      end
    end
  end

  // sequencer state advances only on a taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sfr_pkg::ST_IDLE;
      wait_cnt_r    <= '0;
      phase_idx_r   <= '0;
      phase_ticks_r <= '0;
      shift_r       <= '0;
      last_sts_r    <= sfr_pkg::STS_OK;
    end else if (take) begin
      state_r       <= state_nxt;
      wait_cnt_r    <= wait_cnt_nxt;
      phase_idx_r   <= phase_idx_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      shift_r       <= shift_nxt;
      last_sts_r    <= last_sts_nxt;
    end
  end

  // result word for this sample
  always_comb begin
    res_word.drive_low          = drive;
    res_word.busy_res           = (state_nxt != sfr_pkg::ST_IDLE);
    res_word.done_res           = done;
    res_word.status             = last_sts_nxt;
    res_word.humidity_whole     = shift_nxt[39:32];
    res_word.humidity_tenths    = shift_nxt[31:24];
    res_word.temperature_whole  = shift_nxt[23:16];
    res_word.temperature_tenths = shift_nxt[15:8];
    res_word.received_sum       = shift_nxt[7:0];
  end

endmodule

// ===== sv/sfr_res_q.sv =====
// sfr_res_q: two-word result queue between the sequencer and the pop side
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_res_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  sfr_pkg::res_t din,
  output logic          ready,
  input  logic          pop,
  output logic          empty,
  output sfr_pkg::res_t dout
);

  logic [1:0]    cnt_r, cnt_nxt;
  sfr_pkg::res_t slot0_r, slot1_r;
  logic          pop_fire;

  assign pop_fire = pop && !empty;
  assign empty = (cnt_r == 2'd0);
  assign ready = !cnt_r[1] || pop_fire;
  assign dout = slot0_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !pop_fire) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_fire && !wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // storage slots, oldest word in slot0
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      if (cnt_r == 2'd2) begin
        slot0_r <= slot1_r;
        if (wr) begin
          slot1_r <= din;
        end
      end else if (wr) begin
        slot0_r <= din;
      end
    end else if (wr) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= din;
      end else begin
        slot1_r <= din;
      end
    end
  end

endmodule

// ===== sv/single_wire_sensor_frame_reader_unit.sv =====
// single_wire_sensor_frame_reader_unit: top level of the single-wire sensor frame reader
// depends on sfr_pkg, sfr_front, sfr_back, sfr_res_q
//
// channel  | ports                                      | accepted when
// ---------+--------------------------------------------+---------------------
// input    | in_push, in_full, in_line_level, ...       | in_push && !in_full
// result   | out_empty, out_pop, out_drive_low, ...     | out_pop && !out_empty
// config   | cfg_we, cfg_idx, cfg_wdata                 | cfg_we
//
// one word per clock unless a queue stalls: the sequencer steps one sample per cycle
// a word is held in the input queue, then its result is registered in the result queue
// two-word queues on each side let push and pop stall independently
// synchronous active-low reset restores register defaults and the idle state
`timescale 1ns / 1ps

module single_wire_sensor_frame_reader_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_line_level,
  input  logic       in_start_read,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_drive_low,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [7:0] out_humidity_whole,
  output logic [7:0] out_humidity_tenths,
  output logic [7:0] out_temperature_whole,
  output logic [7:0] out_temperature_tenths,
  output logic [7:0] out_received_sum,
  input  logic                                cfg_we,
  input  logic [sfr_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [sfr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  sfr_pkg::in_word_t in_word, q_word;
  sfr_pkg::res_t     res_word, out_word;
  sfr_pkg::hs_t      hs;
  logic              q_valid;
  logic              res_ready;

  assign in_word.line_level = in_line_level;
  assign in_word.start_read = in_start_read;

  // input side queue
  sfr_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (in_word),
    .full  (in_full),
    .take  (hs.take),
    .valid (q_valid),
    .dout  (q_word)
  );

  // sequencer
  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (q_valid),
    .in_word   (q_word),
    .res_ready (res_ready),
    .hs        (hs),
    .res_word  (res_word)
  );

  // result side queue
  sfr_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (hs.take),
    .din   (res_word),
    .ready (res_ready),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_word)
  );

  assign out_drive_low          = out_word.drive_low;
  assign out_busy_res           = out_word.busy_res;
  assign out_done_res           = out_word.done_res;
  assign out_status             = out_word.status;
  assign out_humidity_whole     = out_word.humidity_whole;
  assign out_humidity_tenths    = out_word.humidity_tenths;
  assign out_temperature_whole  = out_word.temperature_whole;
  assign out_temperature_tenths = out_word.temperature_tenths;
  assign out_received_sum       = out_word.received_sum;

  // the sequencer takes a word only when one is queued
  a_take_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    hs.take |-> hs.valid)
    else $error("sequencer took a word from an empty queue");

  // the line is pulled low only while a read is running
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_drive_low) |-> out_busy_res)
    else $error("line driven low outside a read");

  // a finished read leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_done_res) |-> (!out_busy_res && !out_drive_low))
    else $error("read finished while still busy");

  // status never carries the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status != sfr_pkg::STS_UNUSED))
    else $error("unused status code on result");

endmodule
